[hw/rtl/rdt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply dedup table package
// Payload types, operation codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package rdt_pkg;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_EXPIRE = 2'd2,
    MODE_CLIENT = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] req_key;
    logic [31:0] reply_handle;
    logic [15:0] client_id;
    logic [31:0] now_time;
    logic [31:0] min_age;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic        table_full;
    logic [6:0]  removed_count;
    logic        table_empty;
  } out_t;

  // One table entry as it is kept in the RAM.
  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [31:0] handle;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);
  localparam logic [6:0]  RemovedMax = 7'd127;

  typedef struct packed {
    logic scan_start;   // capture the item and rewind the address counter
    logic scan_step;    // read one entry and advance
    logic clear_write;  // clear one entry during the reset sweep and advance
    logic commit;       // write back the add, if any
    logic load_out;     // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic addr_last;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

[hw/rtl/reply_dedup_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply dedup table
// Duplicate-request cache of recent replies keyed by a 64-bit request ID.
//
// Usage: each transfer on the input channel carries one operation (lookup,
// add, expire by age, remove client) and yields exactly one transfer on the
// output channel, which also reports whether the table is left empty.
// Every operation walks the whole table in the entry RAM, one entry per
// cycle through its single read port, then writes back an add if needed.
// The last entry read is then evaluated, the add is written back and the
// result is loaded into the output register; only then is the next item
// taken. Removals are written in the same pass.
// After reset the block sweeps the RAM to clear all entries; in_ready_o
// stays low during that sweep.
// The result sits in an output register, so a new item is accepted while
// the previous result waits; if the receiver still stalls when the next
// result is ready, the block holds it and takes no further input.
// ----------------------------------------------------------------------------
module reply_dedup_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned CLIENT_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire rdt_pkg::in_t  in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      rdt_pkg::out_t out_data_o
);
  import rdt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  rdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rdt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CLIENT_BITS (CLIENT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hw/rtl/rdt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/rdt_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply dedup table controller
// Sequences the reset sweep, the table scan, the write back and the result.
// ----------------------------------------------------------------------------
module rdt_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire rdt_pkg::ctrl_status_t status_i,
  output      rdt_pkg::ctrl_cmd_t    cmd_o
);
  import rdt_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      // The last entry read is evaluated here.
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

[hw/rtl/rdt_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply dedup table datapath
// Entry RAM, scan address counter, per-entry match logic and result register.
// ----------------------------------------------------------------------------
module rdt_datapath #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned CLIENT_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rdt_pkg::ctrl_cmd_t    cmd_i,
  output      rdt_pkg::ctrl_status_t status_o,
  input  wire rdt_pkg::in_t          in_data_i,
  input  wire logic                  out_ready_i,
  output      logic                  out_valid_o,
  output      rdt_pkg::out_t         out_data_o
);
  import rdt_pkg::*;

  localparam int unsigned AddrWidth  = $clog2(TABLE_DEPTH);
  localparam int unsigned CountWidth = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ClientShift = 64 - CLIENT_BITS;

  logic [AddrWidth-1:0]  addr_q, addr_d, rd_addr_q;
  logic                  addr_last;
  logic                  rd_pend_q;
  in_t                   item_q;
  entry_t                rd_entry;
  logic [EntryWidth-1:0] rd_raw;

  logic                  match_q, free_q;
  logic [AddrWidth-1:0]  match_idx_q, free_idx_q;
  logic [31:0]           handle_q;
  logic [6:0]            removed_q;
  logic [CountWidth-1:0] count_q;

  logic                  key_match, stale, client_match, drop;
  logic [31:0]           limit;
  logic [31:0]           client_top;
  logic                  add_write;

  logic                  we;
  logic [AddrWidth-1:0]  waddr;
  entry_t                wentry;

  logic                  out_valid_q;
  out_t                  out_q;

  assign addr_last = (addr_q == AddrWidth'(TABLE_DEPTH - 1));

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.scan_start) begin
      addr_d = '0;
    end else if (cmd_i.scan_step || cmd_i.clear_write) begin
      addr_d = addr_last ? '0 : addr_q + AddrWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      addr_q    <= addr_d;
      rd_pend_q <= cmd_i.scan_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      rd_addr_q <= addr_q;
    end
    if (cmd_i.scan_start) begin
      item_q <= in_data_i;
    end
  end

  assign rd_entry = entry_t'(rd_raw);

  // Per-entry evaluation, one entry per cycle as read data returns.
  assign limit        = item_q.now_time - item_q.min_age;
  assign key_match    = rd_entry.valid && (rd_entry.key == item_q.req_key);
  assign stale        = rd_entry.valid && (item_q.min_age <= item_q.now_time) &&
                        (rd_entry.stamp < limit);
  assign client_top   = 32'(rd_entry.key >> ClientShift);
  assign client_match = rd_entry.valid && (client_top == 32'(item_q.client_id));

  always_comb begin
    case (item_q.mode)
      MODE_EXPIRE: drop = rd_pend_q && stale;
      MODE_CLIENT: drop = rd_pend_q && client_match;
      default:     drop = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      removed_q <= '0;
    end else if (cmd_i.scan_start) begin
      match_q   <= 1'b0;
      free_q    <= 1'b0;
      removed_q <= '0;
    end else if (rd_pend_q) begin
      if (key_match) begin
        match_q <= 1'b1;
      end
      if (!rd_entry.valid && !free_q) begin
        free_q <= 1'b1;
      end
      if (drop && (removed_q != RemovedMax)) begin
        removed_q <= removed_q + 7'd1;
      end
    end
  end

  // Keys are unique, so at most one entry matches and the last capture is it.
  always_ff @(posedge clk_i) begin
    if (rd_pend_q && key_match) begin
      match_idx_q <= rd_addr_q;
      handle_q    <= rd_entry.handle;
    end
    if (rd_pend_q && !rd_entry.valid && !free_q) begin
      free_idx_q <= rd_addr_q;
    end
  end

  assign add_write = cmd_i.commit && (item_q.mode == MODE_ADD) && (match_q || free_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (drop) begin
      count_q <= count_q - CountWidth'(1);
    end else if (add_write && !match_q) begin
      count_q <= count_q + CountWidth'(1);
    end
  end

  // Write port: reset sweep, removals during the scan, or the add at commit.
  always_comb begin
    we     = 1'b0;
    waddr  = addr_q;
    wentry = '0;
    if (cmd_i.clear_write) begin
      we = 1'b1;
    end else if (drop) begin
      we    = 1'b1;
      waddr = rd_addr_q;
    end else if (add_write) begin
      we            = 1'b1;
      waddr         = match_q ? match_idx_q : free_idx_q;
      wentry.valid  = 1'b1;
      wentry.key    = item_q.req_key;
      wentry.handle = item_q.reply_handle;
      wentry.stamp  = item_q.now_time;
    end
  end

  rdt_ram #(
    .WIDTH (EntryWidth),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .re_i    (cmd_i.scan_step),
    .raddr_i (addr_q),
    .rdata_o (rd_raw)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.hit           <= (item_q.mode == MODE_LOOKUP) && match_q;
      out_q.found_handle  <= ((item_q.mode == MODE_LOOKUP) && match_q) ? handle_q : '0;
      out_q.table_full    <= (item_q.mode == MODE_ADD) && !match_q && !free_q;
      out_q.removed_count <= removed_q;
      out_q.table_empty   <= (count_q == '0);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;
  assign status_o.addr_last = addr_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

[hw/rtl/rdt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Reply dedup table checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rdt_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire rdt_pkg::out_t out_data_o
);
  import rdt_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only one kind of result is flagged per transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.hit && out_data_o.table_full))
    else $error("hit and table_full together");

  // A miss carries no handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |-> out_data_o.found_handle == '0)
    else $error("handle without hit");

  // A lookup hit or a full add removes nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.hit || out_data_o.table_full) |->
      out_data_o.removed_count == '0)
    else $error("removal reported on lookup or add");

  // An input transfer is followed by a busy input side for the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a scan runs");

endmodule

bind reply_dedup_table rdt_checker u_rdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
